// File: rtl/fpa_pkg.sv
`default_nettype none

package fpa_pkg;

  localparam int PAGE_W   = 12;
  localparam int RESULT_W = 10;

  typedef enum logic [2:0] {
    ACT_ALLOC   = 3'd0,
    ACT_DISPOSE = 3'd1,
    ACT_LOOKUP  = 3'd2,
    ACT_NEXT    = 3'd3,
    ACT_PREV    = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_CLOSED  = 3'd1,
    ST_INVALID = 3'd2,
    ST_FREE    = 3'd3,
    ST_EOF     = 3'd4,
    ST_FULL    = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC_RD,
    S_DISP_RD,
    S_LOOK_RD,
    S_SCAN
  } state_t;

  typedef struct packed {
    action_t                    action;
    logic signed [PAGE_W-1:0]   page;
  } req_t;

  typedef struct packed {
    status_t                    status;
    logic        [RESULT_W-1:0] result_page;
  } rsp_t;

endpackage

`default_nettype wire

// File: rtl/fpa_page_mem.sv
`default_nettype none

module fpa_page_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 12
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/free_list_page_allocator.sv
// Free-list page allocator.
// Request channel: req (action, page) is taken on a rising edge with start high and
// busy low. Response channel: done is high for one cycle with rsp (status,
// result_page); the receiver must take it then, there is no back-pressure.
// Configuration: cfg_we writes cfg_wdata into file_open; write only while idle.
// Work done from the accepting edge to the done cycle:
//   closed file, invalid request, pool full, append of a new page: no page memory read
//   pop from the free list, dispose, lookup: one page memory read
//   next / previous scan: one page memory read per page walked, one read per cycle
// An item is accepted as soon as busy is low, including the cycle in which the
// previous result is shown on done.
// Reset clears file_open, the page count and the free list head. The page
// memory is not cleared; only pages below the page count are ever read.
`default_nettype none

module free_list_page_allocator #(
  parameter int MAX_PAGES = 1024
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire fpa_pkg::req_t req,
  output logic               done,
  output fpa_pkg::rsp_t      rsp,
  input  wire logic          cfg_we,
  input  wire logic          cfg_wdata
);

  localparam int IW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int CW = $clog2(MAX_PAGES + 1);
  localparam int PW = ((CW > fpa_pkg::PAGE_W) ? CW : fpa_pkg::PAGE_W) + 1;
  localparam int DW = IW + 2;

  fpa_pkg::state_t state, state_next;

  logic                 file_open;
  logic [CW-1:0]        page_count, page_count_next;
  logic [IW-1:0]        free_head, free_head_next;
  logic                 free_head_valid, free_head_valid_next;
  logic [IW-1:0]        pg, pg_next;
  logic signed [PW-1:0] scan_q, scan_q_next;
  logic                 scan_up, scan_up_next;
  logic                 pend, pend_next;
  logic [IW-1:0]        pend_q, pend_q_next;
  fpa_pkg::rsp_t        rsp_next;

  logic                 mem_we;
  logic [IW-1:0]        mem_waddr;
  logic [DW-1:0]        mem_wdata;
  logic                 mem_re;
  logic [IW-1:0]        mem_raddr;
  logic [DW-1:0]        mem_rdata;
  logic                 rd_used;
  logic                 rd_lv;
  logic [IW-1:0]        rd_link;

  logic signed [PW-1:0] p_ext;
  logic signed [PW-1:0] cnt_ext;
  logic [IW-1:0]        p_idx;
  logic                 p_valid;
  logic                 p_is_m1;
  logic                 p_is_cnt;
  logic                 scan_in_range;

  logic                 fin;
  fpa_pkg::status_t     fin_status;
  logic [IW-1:0]        fin_page;
  logic [IW+fpa_pkg::RESULT_W-1:0] fin_ext;

  fpa_page_mem #(
    .DEPTH (MAX_PAGES),
    .AW    (IW),
    .DW    (DW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign rd_used = mem_rdata[IW+1];
  assign rd_lv   = mem_rdata[IW];
  assign rd_link = mem_rdata[IW-1:0];

  assign p_ext    = PW'(req.page);
  assign cnt_ext  = $signed(PW'(page_count));
  assign p_idx    = p_ext[IW-1:0];
  assign p_valid  = !p_ext[PW-1] && (p_ext < cnt_ext);
  assign p_is_m1  = (p_ext == '1);
  assign p_is_cnt = (p_ext == cnt_ext);

  assign scan_in_range = scan_up ? (scan_q < cnt_ext) : !scan_q[PW-1];

  assign busy = (state != fpa_pkg::S_IDLE);

  always_comb begin
    state_next           = state;
    page_count_next      = page_count;
    free_head_next       = free_head;
    free_head_valid_next = free_head_valid;
    pg_next              = pg;
    scan_q_next          = scan_q;
    scan_up_next         = scan_up;
    pend_next            = pend;
    pend_q_next          = pend_q;
    mem_we               = 1'b0;
    mem_waddr            = '0;
    mem_wdata            = '0;
    mem_re               = 1'b0;
    mem_raddr            = '0;
    fin                  = 1'b0;
    fin_status           = fpa_pkg::ST_OK;
    fin_page             = '0;

    unique case (state)
      fpa_pkg::S_IDLE: begin
        if (start) begin
          pg_next = p_idx;
          if (!file_open) begin
            fin        = 1'b1;
            fin_status = fpa_pkg::ST_CLOSED;
          end else begin
            unique case (req.action)
              fpa_pkg::ACT_ALLOC: begin
                if (free_head_valid) begin
                  mem_re     = 1'b1;
                  mem_raddr  = free_head;
                  state_next = fpa_pkg::S_ALLOC_RD;
                end else if (page_count >= CW'(MAX_PAGES)) begin
                  fin        = 1'b1;
                  fin_status = fpa_pkg::ST_FULL;
                end else begin
                  mem_we          = 1'b1;
                  mem_waddr       = page_count[IW-1:0];
                  mem_wdata       = {1'b1, 1'b0, {IW{1'b0}}};
                  page_count_next = page_count + 1'b1;
                  fin             = 1'b1;
                  fin_page        = page_count[IW-1:0];
                end
              end
              fpa_pkg::ACT_DISPOSE, fpa_pkg::ACT_LOOKUP: begin
                if (!p_valid) begin
                  fin        = 1'b1;
                  fin_status = fpa_pkg::ST_INVALID;
                end else begin
                  mem_re     = 1'b1;
                  mem_raddr  = p_idx;
                  state_next = (req.action == fpa_pkg::ACT_DISPOSE) ?
                               fpa_pkg::S_DISP_RD : fpa_pkg::S_LOOK_RD;
                end
              end
              fpa_pkg::ACT_NEXT: begin
                if (!p_is_m1 && !p_valid) begin
                  fin        = 1'b1;
                  fin_status = fpa_pkg::ST_INVALID;
                end else begin
                  scan_q_next  = p_ext + PW'(1);
                  scan_up_next = 1'b1;
                  pend_next    = 1'b0;
                  state_next   = fpa_pkg::S_SCAN;
                end
              end
              fpa_pkg::ACT_PREV: begin
                if (!p_is_cnt && !p_valid) begin
                  fin        = 1'b1;
                  fin_status = fpa_pkg::ST_INVALID;
                end else begin
                  scan_q_next  = p_ext - PW'(1);
                  scan_up_next = 1'b0;
                  pend_next    = 1'b0;
                  state_next   = fpa_pkg::S_SCAN;
                end
              end
              default: begin
                fin        = 1'b1;
                fin_status = fpa_pkg::ST_INVALID;
              end
            endcase
          end
        end
      end
      fpa_pkg::S_ALLOC_RD: begin
        mem_we               = 1'b1;
        mem_waddr            = free_head;
        mem_wdata            = {1'b1, rd_lv, rd_link};
        free_head_next       = rd_link;
        free_head_valid_next = rd_lv;
        fin                  = 1'b1;
        fin_page             = free_head;
      end
      fpa_pkg::S_DISP_RD: begin
        fin = 1'b1;
        if (!rd_used) begin
          fin_status = fpa_pkg::ST_FREE;
        end else begin
          mem_we               = 1'b1;
          mem_waddr            = pg;
          mem_wdata            = {1'b0, free_head_valid, free_head};
          free_head_next       = pg;
          free_head_valid_next = 1'b1;
        end
      end
      fpa_pkg::S_LOOK_RD: begin
        fin = 1'b1;
        if (rd_used) begin
          fin_page = pg;
        end else begin
          fin_status = fpa_pkg::ST_INVALID;
        end
      end
      fpa_pkg::S_SCAN: begin
        if (pend && rd_used) begin
          fin      = 1'b1;
          fin_page = pend_q;
        end else if (!scan_in_range) begin
          fin        = 1'b1;
          fin_status = fpa_pkg::ST_EOF;
        end else begin
          mem_re      = 1'b1;
          mem_raddr   = scan_q[IW-1:0];
          pend_next   = 1'b1;
          pend_q_next = scan_q[IW-1:0];
          scan_q_next = scan_up ? (scan_q + PW'(1)) : (scan_q - PW'(1));
        end
      end
      default: begin
        state_next = fpa_pkg::S_IDLE;
      end
    endcase

    if (fin) begin
      state_next = fpa_pkg::S_IDLE;
    end
  end

  assign fin_ext = {{fpa_pkg::RESULT_W{1'b0}}, fin_page};

  always_comb begin
    rsp_next.status      = fin_status;
    rsp_next.result_page = fin_ext[fpa_pkg::RESULT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= fpa_pkg::S_IDLE;
      file_open       <= 1'b0;
      page_count      <= '0;
      free_head       <= '0;
      free_head_valid <= 1'b0;
      pend            <= 1'b0;
      done            <= 1'b0;
    end else begin
      state           <= state_next;
      page_count      <= page_count_next;
      free_head       <= free_head_next;
      free_head_valid <= free_head_valid_next;
      pend            <= pend_next;
      done            <= fin;
      if (cfg_we) begin
        file_open <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    pg      <= pg_next;
    scan_q  <= scan_q_next;
    scan_up <= scan_up_next;
    pend_q  <= pend_q_next;
    if (fin) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/fpa_checker.sv
`default_nettype none

module fpa_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          start,
  input wire logic          busy,
  input wire logic          done,
  input wire fpa_pkg::rsp_t rsp
);

  // drop the page number on every failed transaction
  a_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status != fpa_pkg::ST_OK) |-> rsp.result_page == '0)
    else $error("result page not zero on failed transaction");

  // a result follows only an accepted or running transaction
  a_done_has_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || start))
    else $error("result without a transaction");

  // hold busy only after an accepted transaction
  a_busy_from_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy without a transaction");

  // a finished multi-cycle transaction shows its result as busy drops
  a_fall_has_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("transaction ended without a result");

endmodule

bind free_list_page_allocator fpa_checker u_fpa_checker (.*);

`default_nettype wire

// File: bench/free_list_page_allocator_tb.sv
`timescale 1ns / 1ps

module free_list_page_allocator_tb;
  import fpa_pkg::*;

  localparam int MAX_PAGES = 1024;
  localparam int QUIET_LIMIT = 4000;
  localparam action_t ACT_UNUSED = action_t'(3'(int'(ACT_PREV) + 1));

  class page_pool_tracker;
    bit open;
    int count;
    int head;
    bit head_ok;
    int link [MAX_PAGES];
    bit used [MAX_PAGES];
    rsp_t answers_due [$];
    int errors;

    function new();
      open = 1'b0;
      count = 0;
      head = MAX_PAGES;
      head_ok = 1'b0;
      errors = 0;
    endfunction

    function bit holds(int p);
      return p >= 0 && p < count;
    endfunction

    function rsp_t serve(req_t r);
      rsp_t a;
      int p;
      int q;
      int found;
      status_t st;
      p = int'($signed(r.page));
      st = ST_OK;
      found = 0;
      if (!open) begin
        st = ST_CLOSED;
      end else begin
        case (r.action)
          ACT_ALLOC: begin
            if (head_ok && head < count) begin
              found = head;
              if (link[found] < count) begin
                head = link[found];
                head_ok = 1'b1;
              end else begin
                head = MAX_PAGES;
                head_ok = 1'b0;
              end
              used[found] = 1'b1;
            end else if (count >= MAX_PAGES) begin
              st = ST_FULL;
            end else begin
              found = count;
              used[found] = 1'b1;
              count++;
            end
          end
          ACT_DISPOSE: begin
            if (!holds(p)) begin
              st = ST_INVALID;
            end else if (!used[p]) begin
              st = ST_FREE;
            end else begin
              link[p] = head_ok ? head : MAX_PAGES;
              used[p] = 1'b0;
              head = p;
              head_ok = 1'b1;
            end
          end
          ACT_LOOKUP: begin
            if (holds(p) && used[p]) found = p;
            else st = ST_INVALID;
          end
          ACT_NEXT: begin
            if (p != -1 && !holds(p)) begin
              st = ST_INVALID;
            end else begin
              st = ST_EOF;
              for (q = p + 1; q < count; q++) begin
                if (used[q]) begin
                  st = ST_OK;
                  found = q;
                  break;
                end
              end
            end
          end
          ACT_PREV: begin
            if (p != count && !holds(p)) begin
              st = ST_INVALID;
            end else begin
              st = ST_EOF;
              for (q = p - 1; q >= 0; q--) begin
                if (used[q]) begin
                  st = ST_OK;
                  found = q;
                  break;
                end
              end
            end
          end
          default: st = ST_INVALID;
        endcase
      end
      if (st != ST_OK || r.action == ACT_DISPOSE) found = 0;
      a.status = st;
      a.result_page = found[RESULT_W-1:0];
      return a;
    endfunction

    function void take_request(req_t r);
      answers_due.push_back(serve(r));
    endfunction

    function void match_answer(rsp_t got);
      rsp_t want;
      if (answers_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: status %0d page %0d", got.status, got.result_page);
        return;
      end
      want = answers_due.pop_front();
      if (got.status !== want.status || got.result_page !== want.result_page) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected status %0d page %0d, got status %0d page %0d",
                   want.status, want.result_page, got.status, got.result_page);
      end
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t req = '0;
  logic done;
  rsp_t rsp;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;

  page_pool_tracker sb = new();
  bit steady = 1'b0;

  free_list_page_allocator #(
    .MAX_PAGES(MAX_PAGES)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req),
    .done(done),
    .rsp(rsp),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.take_request(req);
      if (done) sb.match_answer(rsp);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || done) quiet = 0;
      else quiet++;
    end
    $display("free_list_page_allocator_tb: FAIL");
    $finish;
  end

  function automatic req_t mk(action_t a, int p);
    req_t r;
    r.action = a;
    r.page = p[PAGE_W-1:0];
    return r;
  endfunction

  // Mostly well-formed requests against the current pool, with some raw noise.
  function automatic req_t pick_request(int cap);
    req_t r;
    int roll;
    int pages;
    int p;
    pages = sb.count;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      r.action = action_t'(3'($urandom()));
      r.page = PAGE_W'($urandom());
      return r;
    end
    roll = $urandom_range(0, 99);
    if (roll < 28) r.action = (sb.head_ok || pages < cap) ? ACT_ALLOC : ACT_DISPOSE;
    else if (roll < 52) r.action = ACT_DISPOSE;
    else if (roll < 68) r.action = ACT_LOOKUP;
    else if (roll < 84) r.action = ACT_NEXT;
    else r.action = ACT_PREV;
    roll = $urandom_range(0, 99);
    if (roll < 75) p = (pages > 0) ? $urandom_range(0, pages - 1) : 0;
    else if (roll < 85) p = (r.action == ACT_NEXT) ? -1 : pages;
    else if (roll < 95) p = pages + $urandom_range(0, 3);
    else p = -$urandom_range(1, 4);
    r.page = p[PAGE_W-1:0];
    return r;
  endfunction

  task automatic send_request(input req_t fixed, input bit random_pick, input int cap);
    req_t r;
    @(negedge clk);
    if (!steady && $urandom_range(0, 99) < 10) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    r = random_pick ? pick_request(cap) : fixed;
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.answers_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_file_open(input bit v);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.open = v;
  endtask

  initial begin
    req_t opening_set [$];
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // closed file
    write_file_open(1'b0);
    send_request(mk(ACT_ALLOC, 0), 1'b0, 0);
    send_request(mk(ACT_LOOKUP, 0), 1'b0, 0);
    send_request(mk(ACT_UNUSED, 3), 1'b0, 0);
    write_file_open(1'b1);

    opening_set = '{mk(ACT_LOOKUP, 0), mk(ACT_NEXT, -1), mk(ACT_PREV, 0),
                    mk(ACT_ALLOC, 0), mk(ACT_ALLOC, 0), mk(ACT_ALLOC, 0), mk(ACT_ALLOC, 0),
                    mk(ACT_DISPOSE, 1), mk(ACT_DISPOSE, 1), mk(ACT_LOOKUP, 1),
                    mk(ACT_NEXT, -1), mk(ACT_NEXT, 0), mk(ACT_PREV, 4), mk(ACT_PREV, 2),
                    mk(ACT_NEXT, 3), mk(ACT_PREV, 0), mk(ACT_DISPOSE, -1),
                    mk(ACT_DISPOSE, 4), mk(ACT_LOOKUP, 2047), mk(ACT_DISPOSE, -2048),
                    mk(ACT_NEXT, -2), mk(ACT_PREV, 5), mk(ACT_UNUSED, 1),
                    mk(ACT_ALLOC, 0), mk(ACT_ALLOC, 0)};
    foreach (opening_set[i]) send_request(opening_set[i], 1'b0, 0);

    for (int i = 0; i < 500; i++) begin
      steady = (i >= 150 && i < 350);
      send_request('0, 1'b1, 48);
    end
    steady = 1'b0;

    // close mid-run; the pool must survive
    write_file_open(1'b0);
    for (int i = 0; i < 25; i++) send_request('0, 1'b1, 160);
    write_file_open(1'b1);

    for (int i = 0; i < 150; i++) send_request('0, 1'b1, 160);

    // fill the pool, then push past full
    while (!(sb.count == MAX_PAGES && !sb.head_ok)) send_request(mk(ACT_ALLOC, 0), 1'b0, 0);
    send_request(mk(ACT_ALLOC, 0), 1'b0, 0);
    send_request(mk(ACT_ALLOC, 0), 1'b0, 0);
    send_request(mk(ACT_PREV, MAX_PAGES), 1'b0, 0);

    for (int i = 0; i < 150; i++) send_request('0, 1'b1, MAX_PAGES);

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.answers_due.size() == 0)
      $display("free_list_page_allocator_tb: PASS");
    else
      $display("free_list_page_allocator_tb: FAIL");
    $finish;
  end

endmodule
